@@ rtl/ocd_pkg.sv @@
// Shared types, widths and codes for the occupancy detector.
package ocd_pkg;

  localparam int PinW        = 8;
  localparam int PinIdxW     = 3;
  localparam int CountW      = 4;
  localparam int DelayW      = 8;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 8;
  localparam int InTdataW    = 16;
  localparam int OutTdataW   = 24;
  localparam int PinCountDef = 8;

  localparam logic [DelayW-1:0] ResetDelay = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLED_PINS  = 1'b0,
    CFG_RELEASE_DELAY = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic sample;
    logic report;
    logic report_all;
    logic sink_accepts;
  } item_ctrl_t;

  typedef struct packed {
    logic               report_valid;
    logic [PinIdxW-1:0] pin_number;
    logic               pin_occupied;
    logic [PinW-1:0]    occupancy_bits;
    logic [PinW-1:0]    pending_bits;
  } result_t;

endpackage

@@ rtl/ocd_lane.sv @@
// One pin qualifier: occupied flag and release counter.
module ocd_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      sample_i,
  input  logic                      level_i,
  input  logic                      reload_i,
  input  logic [ocd_pkg::DelayW-1:0] delay_i,
  output logic                      occupied_o,
  output logic                      occupied_next_o,
  output logic                      changed_o
);
  import ocd_pkg::*;

  logic              occ_q, occ_d;
  logic [DelayW-1:0] cnt_q, cnt_d;

  always_comb begin
    occ_d     = occ_q;
    cnt_d     = cnt_q;
    changed_o = 1'b0;
    if (reload_i) begin
      cnt_d = delay_i;
    end else if (sample_i) begin
      if (!level_i) begin
        occ_d     = 1'b1;
        cnt_d     = delay_i;
        changed_o = !occ_q;
      end else if (occ_q) begin
        if (cnt_q == '0) begin
          occ_d     = 1'b0;
          changed_o = 1'b1;
        end else begin
          cnt_d = cnt_q - DelayW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      cnt_q <= ResetDelay;
    end else begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
    end
  end

  assign occupied_o      = occ_q;
  assign occupied_next_o = occ_d;

  a_free_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(occ_q) |-> $past(cnt_q) == '0)
    else $error("pin freed before its release counter ran out");

endmodule

@@ rtl/ocd_merge.sv @@
// Pending marks, priority scan over the lanes and result assembly.
module ocd_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ocd_pkg::item_ctrl_t      item_i,
  input  logic [ocd_pkg::PinW-1:0] en_mask_i,
  input  logic [ocd_pkg::PinW-1:0] occ_q_i,
  input  logic [ocd_pkg::PinW-1:0] occ_d_i,
  input  logic [ocd_pkg::PinW-1:0] change_i,
  output ocd_pkg::result_t         result_o
);
  import ocd_pkg::*;

  logic [PinW-1:0]    pending_q, pending_d;
  logic [PinW-1:0]    qual;
  logic               found;
  logic [PinIdxW-1:0] pin;

  always_comb begin
    qual  = pending_q & en_mask_i & (item_i.report_all ? {PinW{1'b1}} : occ_q_i);
    found = 1'b0;
    pin   = '0;
    for (int i = 0; i < PinW; i++) begin
      if (qual[i]) begin
        found = 1'b1;
        pin   = PinIdxW'(i);
      end
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (item_i.sample) begin
      pending_d = pending_q | change_i;
    end else if (item_i.report) begin
      pending_d = pending_q & en_mask_i;
      if (found && item_i.sink_accepts) begin
        pending_d[pin] = 1'b0;
      end
    end
  end

  always_comb begin
    result_o.report_valid   = item_i.report && found;
    result_o.pin_number     = result_o.report_valid ? pin : '0;
    result_o.pin_occupied   = result_o.report_valid && occ_q_i[pin];
    result_o.occupancy_bits = occ_d_i;
    result_o.pending_bits   = pending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_report_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.report_valid |-> pending_q[result_o.pin_number] && en_mask_i[result_o.pin_number])
    else $error("reported pin had no pending mark");

  a_accept_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.report_valid && item_i.sink_accepts) |=>
      !pending_q[$past(result_o.pin_number)])
    else $error("accepted report left its pending mark set");

endmodule

@@ rtl/ocd_out_buf.sv @@
// Two-entry output buffer that decouples input ready from output ready.
module ocd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ocd_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ocd_pkg::result_t out_data_o
);
  import ocd_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    in_fire, pop;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pop        = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_fire;
        out_data_d  = in_data_i;
      end
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while the output entry is empty");

endmodule

@@ rtl/occupancy_detector_with_change_report.sv @@
// Top level of the occupancy detector with change report.
// Each accepted input beat yields one result beat, held in the output buffer's registers.
// Throughput: one input beat per cycle; the two-entry output buffer stalls input
// only after two results are left waiting at the output.
// Reset clears occupied and pending masks, sets enabled pins to 0, the release
// delay to 5 and every release counter to 5.
module occupancy_detector_with_change_report #(
  parameter int NumPins = ocd_pkg::PinCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pin_levels[7:0], report_all[8], sink_accepts[9], zero fill
  input  logic [ocd_pkg::InTdataW-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // report_valid[0], pin_number[3:1], pin_occupied[4], occupancy_bits[12:5],
  // pending_bits[20:13], zero fill
  output logic [ocd_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [ocd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ocd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import ocd_pkg::*;

  logic [CountW-1:0] enabled_q, enabled_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [CountW-1:0] cfg_count;
  logic              cfg_enabled_wr;

  logic              in_fire;
  item_ctrl_t        item;
  logic [PinW-1:0]   en_mask;
  logic [PinW-1:0]   occ_q_vec, occ_d_vec, change_vec, reload_vec;
  result_t           result;
  result_t           out_data;

  assign cfg_count = (cfg_data_i[CountW-1:0] > CountW'(NumPins)) ?
                     CountW'(NumPins) : cfg_data_i[CountW-1:0];

  always_comb begin
    enabled_d      = enabled_q;
    delay_d        = delay_q;
    cfg_enabled_wr = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ENABLED_PINS: begin
          enabled_d      = cfg_count;
          cfg_enabled_wr = 1'b1;
        end
        CFG_RELEASE_DELAY: begin
          delay_d = cfg_data_i[DelayW-1:0];
        end
        default: begin
          enabled_d = enabled_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= '0;
      delay_q   <= ResetDelay;
    end else begin
      enabled_q <= enabled_d;
      delay_q   <= delay_d;
    end
  end

  assign in_fire           = s_axis_tvalid && s_axis_tready;
  assign item.sample       = in_fire && (cmd_e'(s_axis_tuser) == CMD_SAMPLE);
  assign item.report       = in_fire && (cmd_e'(s_axis_tuser) == CMD_REPORT);
  assign item.report_all   = s_axis_tdata[PinW];
  assign item.sink_accepts = s_axis_tdata[PinW+1];

  for (genvar g = 0; g < PinW; g++) begin : g_pin
    if (g < NumPins) begin : g_lane
      assign en_mask[g]    = CountW'(g) < enabled_q;
      assign reload_vec[g] = cfg_enabled_wr && (CountW'(g) < cfg_count);

      ocd_lane u_lane (
        .clk_i           (clk_i),
        .rst_ni          (rst_ni),
        .sample_i        (item.sample && en_mask[g]),
        .level_i         (s_axis_tdata[g]),
        .reload_i        (reload_vec[g]),
        .delay_i         (delay_q),
        .occupied_o      (occ_q_vec[g]),
        .occupied_next_o (occ_d_vec[g]),
        .changed_o       (change_vec[g])
      );
    end else begin : g_unused
      assign en_mask[g]    = 1'b0;
      assign reload_vec[g] = 1'b0;
      assign occ_q_vec[g]  = 1'b0;
      assign occ_d_vec[g]  = 1'b0;
      assign change_vec[g] = 1'b0;
    end
  end

  ocd_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .en_mask_i (en_mask),
    .occ_q_i   (occ_q_vec),
    .occ_d_i   (occ_d_vec),
    .change_i  (change_vec),
    .result_o  (result)
  );

  ocd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {{(OutTdataW - 2*PinW - PinIdxW - 2){1'b0}},
                         out_data.pending_bits,
                         out_data.occupancy_bits,
                         out_data.pin_occupied,
                         out_data.pin_number,
                         out_data.report_valid};

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the occupancy detector with change report.
`timescale 1ns / 1ps

module tb;
  import ocd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic       report_valid;
    logic [2:0] pin_number;
    logic       pin_occupied;
    logic [7:0] occupancy_bits;
    logic [7:0] pending_bits;
  } pin_report_t;

  class occupancy_scoreboard;
    logic [3:0]  enabled_q;
    logic [7:0]  delay_q;
    logic [7:0]  occupied_q;
    logic [7:0]  pending_q;
    logic [7:0]  release_cnt_q [8];
    pin_report_t expected_reports [$];
    int          error_count;

    function new();
      enabled_q   = '0;
      delay_q     = ResetDelay;
      occupied_q  = '0;
      pending_q   = '0;
      error_count = 0;
      for (int i = 0; i < 8; i++) release_cnt_q[i] = ResetDelay;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [7:0] data);
      int count;
      count = int'(data[3:0]);
      if (idx == CFG_ENABLED_PINS) begin
        if (count > PinCountDef) count = PinCountDef;
        enabled_q = count[3:0];
        for (int i = 0; i < count; i++) release_cnt_q[i] = delay_q;
      end else begin
        delay_q = data;
      end
    endfunction

    function void note_item(cmd_e cmd, logic [7:0] levels, logic all, logic accepts);
      pin_report_t exp;
      logic        found;
      exp   = '0;
      found = 1'b0;
      if (cmd == CMD_SAMPLE) begin
        for (int i = 0; i < 8; i++) begin
          if (i < int'(enabled_q)) begin
            if (!levels[i]) begin
              if (!occupied_q[i]) begin
                occupied_q[i] = 1'b1;
                pending_q[i]  = 1'b1;
              end
              release_cnt_q[i] = delay_q;
            end else if (occupied_q[i]) begin
              if (release_cnt_q[i] == '0) begin
                occupied_q[i] = 1'b0;
                pending_q[i]  = 1'b1;
              end else begin
                release_cnt_q[i] = release_cnt_q[i] - 8'd1;
              end
            end
          end
        end
      end else begin
        for (int p = 7; p >= 0; p--) begin
          if (!found) begin
            if (p >= int'(enabled_q)) begin
              pending_q[p] = 1'b0;
            end else if (pending_q[p] && (all || occupied_q[p])) begin
              found            = 1'b1;
              exp.report_valid = 1'b1;
              exp.pin_number   = p[2:0];
              exp.pin_occupied = occupied_q[p];
              if (accepts) pending_q[p] = 1'b0;
            end
          end
        end
      end
      exp.occupancy_bits = occupied_q;
      exp.pending_bits   = pending_q;
      expected_reports.push_back(exp);
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
        error_count++;
      end
    endfunction

    function void check_beat(logic [OutTdataW-1:0] tdata);
      pin_report_t exp;
      if (expected_reports.size() == 0) begin
        $error("unexpected result beat 0x%06h", tdata);
        error_count++;
      end else begin
        exp = expected_reports.pop_front();
        compare_field("report_valid", int'(exp.report_valid), int'(tdata[0]));
        compare_field("pin_number", int'(exp.pin_number), int'(tdata[3:1]));
        compare_field("pin_occupied", int'(exp.pin_occupied), int'(tdata[4]));
        compare_field("occupancy_bits", int'(exp.occupancy_bits), int'(tdata[12:5]));
        compare_field("pending_bits", int'(exp.pending_bits), int'(tdata[20:13]));
      end
    endfunction

    function int pending_results();
      return expected_reports.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  occupancy_scoreboard sb;
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  occupancy_detector_with_change_report u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL occupancy_detector_with_change_report");
      $finish;
    end
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      m_axis_tready <= 1'b0;
      hold_served <= hold_requests;
      hold_left <= HoldCycles;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

  task automatic send_item(cmd_e cmd, logic [7:0] levels, logic all, logic accepts);
    logic ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, accepts, all, levels};
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
    sb.note_item(cmd, levels, all, accepts);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] enabled, logic [7:0] delay);
    wait_drained();
    write_reg(CFG_RELEASE_DELAY, delay);
    write_reg(CFG_ENABLED_PINS, enabled);
  endtask

  task automatic run_random(int count);
    logic [7:0] levels;
    cmd_e       cmd;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(99) < 40) ? CMD_REPORT : CMD_SAMPLE;
      if ($urandom_range(99) < 10) begin
        levels = 8'($urandom);
      end else begin
        for (int b = 0; b < 8; b++) levels[b] = ($urandom_range(99) >= 15);
      end
      send_item(cmd, levels, 1'($urandom_range(1)), $urandom_range(99) < 75);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_SAMPLE, 8'h00, 1'b0, 1'b0);
    send_item(CMD_REPORT, 8'hFF, 1'b1, 1'b1);

    set_config(8'd8, 8'd2);
    send_item(CMD_SAMPLE, 8'h00, 1'b1, 1'b1);
    send_item(CMD_REPORT, 8'h00, 1'b0, 1'b0);
    send_item(CMD_REPORT, 8'hFF, 1'b0, 1'b1);
    send_item(CMD_REPORT, 8'h00, 1'b1, 1'b1);
    send_item(CMD_SAMPLE, 8'hFF, 1'b0, 1'b0);
    send_item(CMD_SAMPLE, 8'hFF, 1'b1, 1'b0);
    send_item(CMD_SAMPLE, 8'hFF, 1'b0, 1'b1);
    send_item(CMD_REPORT, 8'hFF, 1'b0, 1'b1);
    send_item(CMD_REPORT, 8'h00, 1'b1, 1'b1);
    send_item(CMD_SAMPLE, 8'h55, 1'b0, 1'b0);
    send_item(CMD_SAMPLE, 8'hAA, 1'b1, 1'b1);
    send_item(CMD_REPORT, 8'h55, 1'b1, 1'b0);
    send_item(CMD_REPORT, 8'hAA, 1'b0, 1'b1);
    send_item(CMD_REPORT, 8'h0F, 1'b0, 1'b1);
    set_config(8'd3, 8'd0);
    send_item(CMD_REPORT, 8'hF0, 1'b1, 1'b1);
    send_item(CMD_SAMPLE, 8'h00, 1'b0, 1'b0);
    send_item(CMD_SAMPLE, 8'hFF, 1'b0, 1'b0);
    send_item(CMD_REPORT, 8'hFF, 1'b0, 1'b1);
    send_item(CMD_REPORT, 8'hFF, 1'b1, 1'b1);
    send_item(CMD_REPORT, 8'hFF, 1'b1, 1'b1);

    set_config(8'd8, 8'd0);
    send_idle_pct = 6;
    rcv_stall_pct = 86;
    hold_requests = hold_requests + 1;
    run_random(100);
    set_config(8'hFF, 8'd255);
    run_random(60);

    set_config(8'd3, 8'd1);
    send_idle_pct = 86;
    rcv_stall_pct = 6;
    run_random(80);
    set_config(8'd0, 8'd3);
    run_random(30);

    set_config(8'd8, 8'd4);
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_requests = hold_requests + 1;
    run_random(150);
    wait_drained();
    write_reg(CFG_ENABLED_PINS, 8'd1);
    write_reg(CFG_RELEASE_DELAY, 8'd0);
    run_random(60);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.pending_results() != 0) begin
      $error("%0d expected results never arrived", sb.pending_results());
    end
    if (sb.error_count == 0 && sb.pending_results() == 0) begin
      $display("PASS occupancy_detector_with_change_report");
    end else begin
      $display("FAIL occupancy_detector_with_change_report");
    end
    $finish;
  end

endmodule
